>>> hdl/bicubic_line_resampler_macros.svh
// Assertion macros for the bicubic line resampler datapath.
`ifndef BICUBIC_LINE_RESAMPLER_MACROS_SVH
`define BICUBIC_LINE_RESAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bicubic line resampler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bicubic line resampler assertion failed");

`endif

>>> hdl/bclr_pkg.sv
// Shared types and constants of the bicubic line resampler.
package bclr_pkg;

  // Field and register widths.
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned STEP_W     = 29;
  localparam int unsigned INV_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 29;
  localparam int unsigned RAW_W      = 32;

  // Up to this many results follow one input request.
  localparam int unsigned MAX_BURST = 4;
  localparam int unsigned BURST_W   = 3;

  // One in unsigned Q16.
  localparam int unsigned Q16_ONE = 65536;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_IN  = 3'd0,
    CFG_LINE_OUT = 3'd1,
    CFG_STEP     = 3'd2,
    CFG_INV      = 3'd3,
    CFG_ALPHA    = 3'd4
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic px_write;
    logic rng_mul;
    logic rng_eval;
    logic k_ad;
    logic k_u;
    logic k_s2;
    logic k_s3;
    logic k_f;
    logic p2_init;
    logic p2_read;
    logic div_load;
    logic div_step;
    logic mac;
    logic out_finish;
    logic emit;
    logic emit_last;
    logic step_done;
  } bclr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop;
    logic early;
    logic taps_empty;
    logic tap_last;
    logic div_last;
    logic out_free;
    logic hold_valid;
  } bclr_sts_t;

endpackage

>>> hdl/bclr_div.sv
// Restoring unsigned divider, one quotient bit per cycle while step_i is high.
module bclr_div
  import bclr_pkg::*;
#(
  parameter int unsigned NUM_W = 62,
  parameter int unsigned DEN_W = 39
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic             last_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Shift one numerator bit into the remainder and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    quo_d = {quo_q[NUM_W-2:0], ge};
    cnt_d = cnt_q + CNT_W'(1);
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = quo_q;
  assign last_o = (cnt_q == CNT_W'(NUM_W - 1));

endmodule

>>> hdl/bclr_dp.sv
// Datapath: configuration, pixel ring, tap weights, kernel, divider and accumulators.
`include "bicubic_line_resampler_macros.svh"

module bclr_dp
  import bclr_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH         = 256,
  parameter int unsigned MAX_LINE             = 4096,
  parameter int unsigned WEIGHT_FRACTION_BITS = 22
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [PIX_W-1:0]      s_data_i,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [PIX_W-1:0]      m_data_o,
  output logic                  m_last_o,
  output logic                  m_user_o,
  input  bclr_cmd_t             cmd_i,
  output bclr_sts_t             sts_o
);

  localparam int unsigned F       = WEIGHT_FRACTION_BITS;
  localparam int unsigned DEPTH_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned LINE_W  = $clog2(MAX_LINE + 1);
  localparam int unsigned CW      = LINE_W + STEP_W + 1;
  localparam int unsigned XW      = CW + 2;
  localparam int unsigned AD_W    = 34;
  localparam int unsigned U_W     = 17;
  localparam int unsigned S2_W    = 2 * U_W;
  localparam int unsigned S3_W    = 3 * U_W;
  localparam int unsigned KF_W    = 58;
  localparam int unsigned SUM_W   = RAW_W + DEPTH_W;
  localparam int unsigned DEN_W   = RAW_W - 1 + DEPTH_W;
  localparam int unsigned NUM_W   = RAW_W + F + DEPTH_W;
  localparam int unsigned ACC_W   = 41 + DEPTH_W;
  localparam int unsigned N_W     = DEPTH_W + 1;
  localparam int unsigned PRD_W   = AD_W + INV_W;
  localparam logic signed [KF_W-1:0] K_TWO49 = KF_W'(64'd562949953421312);
  localparam logic signed [KF_W-1:0] K_TWO50 = KF_W'(64'd1125899906842624);
  localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(64'd2147483648);
  localparam logic [NUM_W-1:0] LIM_POS = NUM_W'(64'd2147483647);

  // Configuration registers.
  logic [LEN_W-1:0]  line_in_q, line_out_q;
  logic [STEP_W-1:0] step_q;
  logic [INV_W-1:0]  inv_q;
  logic              alpha_q;

  // Line position and burst state.
  logic [LINE_W-1:0]  seen_q, next_q, count_q;
  logic [BURST_W-1:0] k_q;
  logic               hold_valid_q, out_valid_q;

  // Output position and tap range.
  logic [CW-1:0]     c_q;
  logic [LINE_W-1:0] lo_q, hi_q;
  logic [N_W-1:0]    n_q, i_q;

  // Kernel pipeline registers.
  logic [AD_W-1:0]  ad_q;
  logic             big_q, kz_q;
  logic [U_W-1:0]   u_q;
  logic [S2_W-1:0]  s2_q;
  logic [S3_W-1:0]  s3_q;
  logic signed [SUM_W-1:0] sum_q;

  // Pass two registers.
  logic signed [RAW_W-1:0] raw_rd_q;
  logic [PIX_W-1:0]        px_rd_q;
  logic                    neg_q;
  logic signed [ACC_W-1:0] acc_q [4];

  // Result held until the next output decides the burst end, and output stage.
  logic [PIX_W-1:0] hold_data_q, out_data_q;
  logic             hold_eol_q, out_last_q, out_user_q;

  // Memories.
  logic [PIX_W-1:0] win_mem [WINDOW_DEPTH];
  logic [RAW_W-1:0] tap_mem [WINDOW_DEPTH];

  logic [LINE_W-1:0]  in_len, out_len;
  logic [STEP_W-1:0]  s_eff;
  logic [DEPTH_W-1:0] win_wr_idx, win_rd_idx, tap_idx;
  logic [LINE_W:0]    tap_pos;
  logic               out_free;

  // Effective lengths and scale.
  always_comb begin
    if (line_in_q == '0) begin
      in_len = LINE_W'(1);
    end else if (32'(line_in_q) > 32'(MAX_LINE)) begin
      in_len = LINE_W'(MAX_LINE);
    end else begin
      in_len = LINE_W'(line_in_q);
    end
    if (line_out_q == '0) begin
      out_len = LINE_W'(1);
    end else if (32'(line_out_q) > 32'(MAX_LINE)) begin
      out_len = LINE_W'(MAX_LINE);
    end else begin
      out_len = LINE_W'(line_out_q);
    end
    s_eff = (step_q < STEP_W'(Q16_ONE)) ? STEP_W'(Q16_ONE) : step_q;
  end

  assign tap_pos    = (LINE_W + 1)'(lo_q) + (LINE_W + 1)'(i_q);
  assign win_wr_idx = DEPTH_W'(seen_q);
  assign win_rd_idx = DEPTH_W'(tap_pos);
  assign tap_idx    = DEPTH_W'(i_q);
  assign out_free   = !out_valid_q || m_ready_i;

  // Tap range of the current output position.
  logic signed [XW-1:0] low_s;
  logic [XW-1:0] high_u, lo0, hi0, n0, lo_d, n_d;
  always_comb begin
    low_s  = $signed(XW'(c_q)) + $signed(XW'(Q16_ONE)) - $signed(XW'({s_eff, 2'b00}));
    high_u = (XW'(c_q) + XW'(Q16_ONE) + XW'({s_eff, 2'b00})) >> 17;
    lo0    = low_s[XW-1] ? '0 : (XW'(low_s) >> 17);
    hi0    = (high_u > XW'(in_len)) ? XW'(in_len) : high_u;
    n0     = (hi0 > lo0) ? (hi0 - lo0) : '0;
    if (n0 > XW'(WINDOW_DEPTH)) begin
      n_d  = XW'(WINDOW_DEPTH);
      lo_d = hi0 - XW'(WINDOW_DEPTH);
    end else begin
      n_d  = n0;
      lo_d = lo0;
    end
  end

  // Distance from the output center, in Q17.
  logic signed [XW-1:0] tap_off;
  logic [XW-1:0] adist;
  always_comb begin
    tap_off = $signed(XW'({tap_pos, 17'b0})) + $signed(XW'(Q16_ONE)) - $signed(XW'(c_q));
    adist   = tap_off[XW-1] ? XW'(-tap_off) : XW'(tap_off);
  end

  // Kernel argument in Q16.
  logic [PRD_W-1:0] u_prod;
  logic [AD_W-1:0]  u_full;
  always_comb begin
    u_prod = PRD_W'(ad_q) * PRD_W'(inv_q) + PRD_W'(Q16_ONE);
    u_full = u_prod[PRD_W-1:17];
  end

  // Kernel polynomial in Q49, rounded to a Q30 weight.
  logic signed [KF_W-1:0] fk, s3s, s2sh, us;
  logic [KF_W-1:0] fmag, mrnd;
  logic signed [RAW_W-1:0] raw_d;
  always_comb begin
    s3s  = $signed(KF_W'(s3_q));
    s2sh = $signed(KF_W'(s2_q)) <<< 16;
    us   = $signed(KF_W'(u_q));
    if (!u_q[U_W-1]) begin
      fk = 3 * s3s - 5 * s2sh + K_TWO49;
    end else begin
      fk = -(s3s - 5 * s2sh + (us <<< 35) - K_TWO50);
    end
    fmag = fk[KF_W-1] ? KF_W'(-fk) : KF_W'(fk);
    mrnd = (fmag + KF_W'(1 << 18)) >> 19;
    if (kz_q) begin
      raw_d = '0;
    end else if (fk[KF_W-1]) begin
      raw_d = -$signed(RAW_W'(mrnd));
    end else begin
      raw_d = $signed(RAW_W'(mrnd));
    end
  end

  // Divider operands for the weight normalization.
  logic [RAW_W-1:0] wabs;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic             neg_d;
  always_comb begin
    wabs = raw_rd_q[RAW_W-1] ? RAW_W'(-raw_rd_q) : RAW_W'(raw_rd_q);
    if (sum_q == '0) begin
      den   = DEN_W'(1 << 30);
      neg_d = raw_rd_q[RAW_W-1];
    end else begin
      den   = sum_q[SUM_W-1] ? DEN_W'(-sum_q) : DEN_W'(sum_q);
      neg_d = (raw_rd_q[RAW_W-1] != sum_q[SUM_W-1]) && (raw_rd_q != '0);
    end
    num = (NUM_W'(wabs) << F) + NUM_W'(den >> 1);
  end

  logic [NUM_W-1:0] quo;
  logic             div_last;

  bclr_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(cmd_i.div_load),
    .step_i(cmd_i.div_step),
    .num_i (num),
    .den_i (den),
    .quo_o (quo),
    .last_o(div_last)
  );

  // Saturated signed weight and the four channel products.
  logic [32:0]             wmag;
  logic signed [32:0]      wneg;
  logic signed [RAW_W-1:0] wt;
  logic signed [40:0]      prod [4];
  always_comb begin
    if (neg_q) begin
      wmag = (quo > LIM_NEG) ? 33'(LIM_NEG) : 33'(quo);
      wneg = -$signed(wmag);
      wt   = RAW_W'(wneg);
    end else begin
      wmag = (quo > LIM_POS) ? 33'(LIM_POS) : 33'(quo);
      wneg = $signed(wmag);
      wt   = RAW_W'(wmag);
    end
    for (int ch = 0; ch < 4; ch++) begin
      prod[ch] = $signed({1'b0, px_rd_q[ch*CH_W +: CH_W]}) * wt;
    end
  end

  // Clamp the accumulators to 0..255; alpha reads 255 when alpha mode is off.
  logic [PIX_W-1:0]        clip_data;
  logic signed [ACC_W-1:0] shv;
  always_comb begin
    clip_data = '0;
    shv       = '0;
    for (int ch = 0; ch < 4; ch++) begin
      shv = acc_q[ch] >>> F;
      if (acc_q[ch][ACC_W-1]) begin
        clip_data[ch*CH_W +: CH_W] = '0;
      end else if (shv > $signed(ACC_W'(255))) begin
        clip_data[ch*CH_W +: CH_W] = 8'hFF;
      end else begin
        clip_data[ch*CH_W +: CH_W] = CH_W'(shv);
      end
    end
    if (!alpha_q) begin
      clip_data[3*CH_W +: CH_W] = 8'hFF;
    end
  end

  // Control state: configuration, counters and valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_in_q    <= LEN_W'(1);
      line_out_q   <= LEN_W'(1);
      step_q       <= STEP_W'(Q16_ONE);
      inv_q        <= INV_W'(Q16_ONE);
      alpha_q      <= 1'b0;
      seen_q       <= '0;
      next_q       <= '0;
      k_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LINE_IN:  line_in_q  <= LEN_W'(cfg_wdata_i);
          CFG_LINE_OUT: line_out_q <= LEN_W'(cfg_wdata_i);
          CFG_STEP:     step_q     <= cfg_wdata_i;
          CFG_INV:      inv_q      <= INV_W'(cfg_wdata_i);
          CFG_ALPHA:    alpha_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.out_finish) begin
        next_q       <= next_q + LINE_W'(1);
        k_q          <= k_q + BURST_W'(1);
        hold_valid_q <= 1'b1;
      end else if (cmd_i.emit) begin
        hold_valid_q <= 1'b0;
      end
      if (cmd_i.step_done) begin
        k_q <= '0;
        if (count_q >= in_len) begin
          seen_q <= '0;
          next_q <= '0;
        end else begin
          seen_q <= count_q;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tap counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
    end else if (cmd_i.rng_eval || cmd_i.p2_init) begin
      i_q <= '0;
    end else if (cmd_i.k_f || cmd_i.mac) begin
      i_q <= i_q + N_W'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.px_write) begin
      count_q <= seen_q + LINE_W'(1);
    end
    if (cmd_i.rng_mul) begin
      c_q <= CW'({next_q, 1'b1}) * CW'(s_eff);
    end
    if (cmd_i.rng_eval) begin
      lo_q  <= LINE_W'(lo_d);
      hi_q  <= LINE_W'(hi0);
      n_q   <= N_W'(n_d);
      sum_q <= '0;
    end
    if (cmd_i.k_ad) begin
      ad_q  <= AD_W'(adist);
      big_q <= |(adist >> AD_W);
    end
    if (cmd_i.k_u) begin
      u_q  <= U_W'(u_full);
      kz_q <= big_q || (|(u_full >> U_W));
    end
    if (cmd_i.k_s2) begin
      s2_q <= S2_W'(u_q) * S2_W'(u_q);
    end
    if (cmd_i.k_s3) begin
      s3_q <= S3_W'(s2_q) * S3_W'(u_q);
    end
    if (cmd_i.k_f) begin
      sum_q <= sum_q + SUM_W'(raw_d);
    end
    if (cmd_i.div_load) begin
      neg_q <= neg_d;
    end
    if (cmd_i.p2_init) begin
      for (int ch = 0; ch < 4; ch++) begin
        acc_q[ch] <= ACC_W'(1) <<< (F - 1);
      end
    end else if (cmd_i.mac) begin
      for (int ch = 0; ch < 4; ch++) begin
        acc_q[ch] <= acc_q[ch] + ACC_W'(prod[ch]);
      end
    end
    if (cmd_i.out_finish) begin
      hold_data_q <= clip_data;
      hold_eol_q  <= (next_q == out_len - LINE_W'(1));
    end
    if (cmd_i.emit) begin
      out_data_q <= hold_data_q;
      out_last_q <= hold_eol_q;
      out_user_q <= cmd_i.emit_last;
    end
  end

  // Pixel ring: written on each input request, read with a registered port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.px_write) begin
      win_mem[win_wr_idx] <= s_data_i;
    end
    if (cmd_i.p2_read) begin
      px_rd_q <= win_mem[win_rd_idx];
    end
  end

  // Raw tap weights of the current output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.k_f) begin
      tap_mem[tap_idx] <= RAW_W'(raw_d);
    end
    if (cmd_i.p2_read) begin
      raw_rd_q <= $signed(tap_mem[tap_idx]);
    end
  end

  // Status back to the controller.
  always_comb begin
    sts_o.stop       = (k_q == BURST_W'(MAX_BURST)) || (next_q >= out_len);
    sts_o.early      = (hi_q > count_q);
    sts_o.taps_empty = (n_q == '0);
    sts_o.tap_last   = (i_q == n_q - N_W'(1));
    sts_o.div_last   = div_last;
    sts_o.out_free   = out_free;
    sts_o.hold_valid = hold_valid_q;
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;
  assign m_user_o  = out_user_q;

  // A held result moves on only into a free output stage.
  `BCLR_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd_i.emit, !out_valid_q || m_ready_i)
  // A new result never overwrites one still held, nor exceeds the burst.
  `BCLR_ASSERT_IMP(a_fin_hold, clk_i, rst_ni, cmd_i.out_finish, !hold_valid_q && (k_q < BURST_W'(MAX_BURST)))
  // A new input request starts with an empty burst.
  `BCLR_ASSERT_IMP(a_accept_clean, clk_i, rst_ni, cmd_i.px_write, !hold_valid_q && (k_q == '0))
  // An emitted result shows up as valid in the next cycle.
  `BCLR_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, cmd_i.emit, out_valid_q)

endmodule

>>> hdl/bclr_ctrl.sv
// Controller state machine sequencing tap range, kernel, normalization and filtering.
module bclr_ctrl
  import bclr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  bclr_sts_t sts_i,
  output bclr_cmd_t cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_RMUL  = 16'b0000_0000_0000_0010,
    S_REVAL = 16'b0000_0000_0000_0100,
    S_CHECK = 16'b0000_0000_0000_1000,
    S_KAD   = 16'b0000_0000_0001_0000,
    S_KU    = 16'b0000_0000_0010_0000,
    S_KS2   = 16'b0000_0000_0100_0000,
    S_KS3   = 16'b0000_0000_1000_0000,
    S_KF    = 16'b0000_0001_0000_0000,
    S_P2I   = 16'b0000_0010_0000_0000,
    S_RD    = 16'b0000_0100_0000_0000,
    S_DLD   = 16'b0000_1000_0000_0000,
    S_DIV   = 16'b0001_0000_0000_0000,
    S_MAC   = 16'b0010_0000_0000_0000,
    S_FIN   = 16'b0100_0000_0000_0000,
    S_FLUSH = 16'b1000_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.px_write = 1'b1;
          state_d        = S_RMUL;
        end
      end
      S_RMUL: begin
        if (sts_i.stop) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.rng_mul = 1'b1;
          state_d       = S_REVAL;
        end
      end
      S_REVAL: begin
        cmd_o.rng_eval = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.early) begin
          state_d = S_FLUSH;
        end else if (!sts_i.hold_valid || sts_i.out_free) begin
          // The previous result was not the last of the burst.
          cmd_o.emit = sts_i.hold_valid;
          state_d    = sts_i.taps_empty ? S_P2I : S_KAD;
        end
      end
      S_KAD: begin
        cmd_o.k_ad = 1'b1;
        state_d    = S_KU;
      end
      S_KU: begin
        cmd_o.k_u = 1'b1;
        state_d   = S_KS2;
      end
      S_KS2: begin
        cmd_o.k_s2 = 1'b1;
        state_d    = S_KS3;
      end
      S_KS3: begin
        cmd_o.k_s3 = 1'b1;
        state_d    = S_KF;
      end
      S_KF: begin
        cmd_o.k_f = 1'b1;
        state_d   = sts_i.tap_last ? S_P2I : S_KAD;
      end
      S_P2I: begin
        cmd_o.p2_init = 1'b1;
        state_d       = sts_i.taps_empty ? S_FIN : S_RD;
      end
      S_RD: begin
        cmd_o.p2_read = 1'b1;
        state_d       = S_DLD;
      end
      S_DLD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        state_d   = sts_i.tap_last ? S_FIN : S_RD;
      end
      S_FIN: begin
        cmd_o.out_finish = 1'b1;
        state_d          = S_RMUL;
      end
      S_FLUSH: begin
        if (!sts_i.hold_valid) begin
          cmd_o.step_done = 1'b1;
          state_d         = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.step_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/bicubic_line_resampler.sv
// A pixel completing no output goes through the range and flush states before ready returns.
// Each output runs the serial kernel sequence over its n taps, then the bit-serial weight divider
// and a multiply-accumulate for each tap; the burst is closed in a final flush state.
// Up to four outputs follow one input pixel; results wait in an output register.
// Asynchronous active-low reset clears counters and valid flags and sets the configuration to its defaults.
module bicubic_line_resampler
  import bclr_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH         = 256,
  parameter int unsigned MAX_LINE             = 4096,
  parameter int unsigned WEIGHT_FRACTION_BITS = 22
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // red_in, green_in, blue_in, alpha_in
  input  logic [PIX_W-1:0]      s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [PIX_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tlast,
  // end_of_burst
  output logic                  m_axis_tuser
);

  bclr_cmd_t cmd;
  bclr_sts_t sts;

  bclr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  bclr_dp #(
    .WINDOW_DEPTH        (WINDOW_DEPTH),
    .MAX_LINE            (MAX_LINE),
    .WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_data_i   (s_axis_tdata),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast),
    .m_user_o   (m_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

>>> tb/sv/tb_bicubic_line_resampler.sv
// Self-checking testbench for the bicubic line resampler with a built-in fixed-point predictor.
`timescale 1ns / 1ps

module tb_bicubic_line_resampler;
  import bclr_pkg::*;

  localparam int unsigned WIN   = 256;
  localparam int unsigned WFB   = 22;
  localparam int unsigned LMAX  = 4096;
  localparam longint      ONE16 = 64'sd65536;

  // One output pixel as it should leave the block.
  typedef struct {
    logic [PIX_W-1:0] pix;
    bit               eol;
    bit               eob;
  } resampled_t;

  // Directed stimulus: alpha mode, source pixel, and whether the result is typed in.
  typedef struct {
    bit               alpha_on;
    logic [PIX_W-1:0] pix;
    bit               typed;
  } pix_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  bicubic_line_resampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state and its copy of the registers.
  logic [PIX_W-1:0] line_win [WIN];
  int unsigned      seen_cnt;
  int unsigned      out_idx;
  int unsigned      reg_in_len;
  int unsigned      reg_out_len;
  int unsigned      reg_step;
  int unsigned      reg_inv;
  bit               reg_alpha;

  resampled_t  pending_q[$];
  int unsigned err_cnt = 0;
  int unsigned hold_off = 0;
  bit          sink_gaps_on = 1'b1;
  bit          src_gaps_on = 1'b1;

  task automatic report(input string what, input longint want, input longint got);
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    err_cnt++;
  endtask

  function automatic int unsigned clamp_len(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > LMAX) return LMAX;
    return raw;
  endfunction

  // Cubic kernel in Q30 for a Q16 argument magnitude.
  function automatic longint kernel_q30(longint unsigned u);
    longint s, s2, s3, f;
    if (u >= 2 * ONE16) return 0;
    s  = longint'(u);
    s2 = s * s;
    s3 = s2 * s;
    if (u < ONE16)
      f = 3 * s3 - 5 * s2 * ONE16 + (64'sd1 <<< 49);
    else
      f = -(s3 - 5 * s2 * ONE16 + 8 * s * (64'sd1 <<< 32) - 4 * (64'sd1 <<< 48));
    if (f >= 0) return (f + (64'sd1 <<< 18)) >>> 19;
    return -((-f + (64'sd1 <<< 18)) >>> 19);
  endfunction

  // Weight normalized by the sum and rounded half away from zero.
  function automatic longint norm_weight(longint w, longint sum);
    longint unsigned num, den, q;
    bit neg;
    num = longint'(w < 0 ? -w : w) << WFB;
    if (sum == 0) begin
      den = 64'd1 << 30;
      neg = (w < 0);
    end else begin
      den = longint'(sum < 0 ? -sum : sum);
      neg = ((w < 0) != (sum < 0)) && (w != 0);
    end
    q = (num + den / 2) / den;
    if (neg) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return longint'(q);
  endfunction

  function automatic logic [7:0] clip_chan(longint acc);
    longint v;
    if (acc < 0) return 8'd0;
    v = acc >>> WFB;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Tap span [lo, hi) and Q17 center of output position xx.
  function automatic void tap_span(int unsigned xx, int unsigned in_len,
                                   output longint lo, output longint hi, output longint c17);
    longint s, low;
    s   = (reg_step < ONE16) ? ONE16 : longint'(reg_step);
    c17 = (2 * longint'(xx) + 1) * s;
    low = c17 + ONE16 - 4 * s;
    hi  = (c17 + ONE16 + 4 * s) >>> 17;
    lo  = (low < 0) ? 0 : (low >>> 17);
    if (hi > longint'(in_len)) hi = in_len;
  endfunction

  function automatic logic [PIX_W-1:0] filter_pixel(int unsigned xx, int unsigned in_len);
    longint lo, hi, c17, n, sum, d;
    longint unsigned ad, u;
    longint raw [WIN];
    longint wt [WIN];
    longint acc [4];
    logic [PIX_W-1:0] px, res;
    tap_span(xx, in_len, lo, hi, c17);
    n = hi - lo;
    sum = 0;
    if (n < 0) n = 0;
    // Kernels wider than the window keep only the newest taps.
    if (n > WIN) begin
      n  = WIN;
      lo = hi - WIN;
    end
    for (int i = 0; i < n; i++) begin
      d = (lo + i) * 131072 + ONE16 - c17;
      ad = (d < 0) ? -d : d;
      u = (ad * reg_inv + 64'd65536) >> 17;
      raw[i] = kernel_q30(u);
      sum += raw[i];
    end
    for (int i = 0; i < n; i++) wt[i] = norm_weight(raw[i], sum);
    for (int ch = 0; ch < 4; ch++) acc[ch] = 64'sd1 <<< (WFB - 1);
    for (int i = 0; i < n; i++) begin
      px = line_win[(lo + i) % WIN];
      for (int ch = 0; ch < 4; ch++) acc[ch] += longint'(px[8*ch +: 8]) * wt[i];
    end
    for (int ch = 0; ch < 3; ch++) res[8*ch +: 8] = clip_chan(acc[ch]);
    res[31:24] = reg_alpha ? clip_chan(acc[3]) : 8'hFF;
    return res;
  endfunction

  // Advances the predictor by one source pixel and queues the outputs it releases.
  task automatic resample_pixel(input logic [PIX_W-1:0] pix, input bit typed);
    int unsigned in_len, out_len, cnt, k;
    longint lo, hi, c17;
    resampled_t r;
    in_len  = clamp_len(reg_in_len);
    out_len = clamp_len(reg_out_len);
    line_win[seen_cnt % WIN] = pix;
    cnt = seen_cnt + 1;
    k = 0;
    while (k < MAX_BURST && out_idx < out_len) begin
      tap_span(out_idx, in_len, lo, hi, c17);
      if (hi > cnt) break;
      r.pix = filter_pixel(out_idx, in_len);
      // Under the reset setup one tap of weight one passes the pixel through.
      if (typed) r.pix = reg_alpha ? pix : {8'hFF, pix[23:0]};
      r.eol = (out_idx == out_len - 1);
      r.eob = 1'b0;
      pending_q.insert(pending_q.size(), r);
      out_idx++;
      k++;
    end
    if (k > 0) pending_q[pending_q.size() - 1].eob = 1'b1;
    if (cnt >= in_len) begin
      seen_cnt = 0;
      out_idx  = 0;
    end else begin
      seen_cnt = cnt;
    end
  endtask

  // Result side: compare each accepted result and draw the stall before the next.
  always @(posedge clk_i) begin : result_sink
    int unsigned gap;
    resampled_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          report("unexpected result", 0, m_axis_tdata);
        end else begin
          want = pending_q.pop_front();
          for (int ch = 0; ch < 4; ch++)
            if (m_axis_tdata[8*ch +: 8] !== want.pix[8*ch +: 8])
              report($sformatf("channel %0d", ch), want.pix[8*ch +: 8], m_axis_tdata[8*ch +: 8]);
          if (m_axis_tlast !== want.eol) report("end of line", want.eol, m_axis_tlast);
          if (m_axis_tuser !== want.eob) report("end of burst", want.eob, m_axis_tuser);
        end
        gap = sink_gaps_on ? $urandom_range(0, 10) : 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    resample_pixel(pix, typed);
    gap = src_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits for every pending result, then for a pixel that releases none to finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(input int unsigned in_len, input int unsigned out_len,
                            input int unsigned step, input int unsigned inv, input bit alpha);
    int unsigned vals [5];
    cfg_idx_e idx;
    vals = '{in_len, out_len, step, inv, alpha};
    idx = idx.first();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    reg_in_len  = in_len & 32'h1FFF;
    reg_out_len = out_len & 32'h1FFF;
    reg_step    = step & 32'h1FFF_FFFF;
    reg_inv     = inv & 32'h1FFFF;
    reg_alpha   = alpha;
  endtask

  task automatic run_phase(input int unsigned in_len, input int unsigned out_len,
                           input int unsigned step, input int unsigned inv, input bit alpha,
                           input int unsigned pixels);
    drain();
    write_regs(in_len, out_len, step, inv, alpha);
    src_gaps_on  = ($urandom_range(0, 3) != 0);
    sink_gaps_on = ($urandom_range(0, 3) != 0);
    repeat (pixels) send_pixel($urandom, 1'b0);
  endtask

  pix_row_t pix_rows [10] = '{
    '{1'b0, 32'h0000_0000, 1'b1},
    '{1'b0, 32'hFFFF_FFFF, 1'b1},
    '{1'b0, 32'hA5A5_5A5A, 1'b1},
    '{1'b0, 32'h5A5A_A5A5, 1'b1},
    '{1'b0, 32'h00FF_00FF, 1'b1},
    '{1'b1, 32'hFF00_FF00, 1'b1},
    '{1'b1, 32'h0000_0000, 1'b1},
    '{1'b1, 32'hFFFF_FFFF, 1'b1},
    '{1'b1, 32'h8001_7F80, 1'b1},
    '{1'b1, 32'h1234_5678, 1'b1}
  };

  initial begin : stimulus
    int unsigned done_items, in_len, out_len, step, inv, pixels;
    for (int i = 0; i < WIN; i++) line_win[i] = '0;
    seen_cnt = 0;
    out_idx  = 0;
    reg_in_len = 1; reg_out_len = 1; reg_step = Q16_ONE; reg_inv = Q16_ONE; reg_alpha = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset setup: one tap, so each pixel comes straight back.
    foreach (pix_rows[i]) begin
      if (pix_rows[i].alpha_on != reg_alpha) begin
        drain();
        write_regs(1, 1, Q16_ONE, Q16_ONE, pix_rows[i].alpha_on);
      end
      send_pixel(pix_rows[i].pix, pix_rows[i].typed);
    end

    // Half-size line with matched registers, then a stall long enough to back up the input.
    run_phase(8, 4, 2 * Q16_ONE, Q16_ONE / 2, 1'b1, 8);
    drain();
    write_regs(16, 16, Q16_ONE, Q16_ONE, 1'b0);
    hold_off = 3000;
    repeat (16) send_pixel($urandom, 1'b0);
    // Output longer than input.
    run_phase(4, 16, Q16_ONE, Q16_ONE, 1'b1, 8);
    // Zero lengths, scale below one and a zero reciprocal.
    run_phase(0, 0, 0, 0, 1'b1, 3);
    // Largest lengths and scale with the smallest nonzero reciprocal, ended early by the next setup.
    run_phase(8191, 8191, 29'h1FFF_FFFF, 1, 1'b0, 6);
    run_phase(20, 3, 29'h1FFF_FFFF, 17'h1FFFF, 1'b1, 14);
    // Kernel wider than the pixel window.
    run_phase(258, 2, 104 * Q16_ONE, 630, 1'b1, 258);

    // Random lines, mostly with matched registers.
    done_items = 0;
    while (done_items < 36) begin
      if ($urandom_range(0, 7) == 0) begin
        in_len  = $urandom_range(1, 24);
        out_len = $urandom_range(1, 40);
        step    = $urandom_range(0, 1 << 19);
        inv     = $urandom_range(0, 17'h1FFFF);
      end else begin
        in_len  = $urandom_range(6, 24);
        step    = $urandom_range(Q16_ONE, 4 * Q16_ONE);
        out_len = (in_len * Q16_ONE) / step;
        if (out_len == 0) out_len = 1;
        inv     = ((64'd1 << 32) + step / 2) / step;
      end
      pixels = in_len * $urandom_range(1, 2);
      run_phase(in_len, out_len, step, inv, $urandom_range(0, 1), pixels);
      done_items += pixels;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0)
      $display("tb_bicubic_line_resampler: done, clean");
    else
      $display("tb_bicubic_line_resampler: done, errors");
    $finish;
  end

  initial begin : watchdog
    #40ms;
    $display("tb_bicubic_line_resampler: done, errors");
    $finish;
  end

endmodule
